@@ rtl/hcb_pkg.sv @@
// ----------------------------------------------------------------------------
// hcb_pkg
// Shared sizes, types and state codes of the Huffman code builder.
// ----------------------------------------------------------------------------
package hcb_pkg;

  localparam int MAX_SYMBOLS = 32;
  localparam int COUNT_BITS  = 24;
  localparam int SYM_W       = 8;
  localparam int CODE_W      = 31;
  localparam int LEN_W       = 5;
  localparam int NODE_DEPTH  = 2 * MAX_SYMBOLS - 1;
  localparam int NODE_IDX_W  = $clog2(NODE_DEPTH);
  localparam int LEAF_IDX_W  = $clog2(MAX_SYMBOLS);
  localparam int LEAF_CNT_W  = $clog2(MAX_SYMBOLS + 1);
  localparam int WEIGHT_W    = COUNT_BITS + $clog2(MAX_SYMBOLS);

  typedef logic [NODE_IDX_W-1:0] node_idx_t;
  typedef logic [LEAF_IDX_W-1:0] leaf_idx_t;
  typedef logic [LEAF_CNT_W-1:0] leaf_cnt_t;
  typedef logic [WEIGHT_W-1:0]   weight_t;

  // two-smallest search packet travelling along the node cells
  typedef struct packed {
    logic      go;
    logic      v1;
    node_idx_t idx1;
    weight_t   w1;
    logic      v2;
    node_idx_t idx2;
    weight_t   w2;
  } scan_t;

  // merge broadcast to every cell
  typedef struct packed {
    logic      en;
    node_idx_t left;
    node_idx_t right;
    node_idx_t parent;
    weight_t   weight;
  } merge_t;

  // code entry held by one leaf cell
  typedef struct packed {
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } leaf_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_INIT,
    S_SCAN,
    S_WAIT,
    S_EMIT
  } state_e;

endpackage

@@ rtl/hcb_node_cell.sv @@
// ----------------------------------------------------------------------------
// hcb_node_cell
// One tree node: weight and linked flag, plus one stage of the
// two-smallest search chain.
// ----------------------------------------------------------------------------
module hcb_node_cell import hcb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  node_idx_t cell_idx_i,
  input  logic      wr_en_i,
  input  node_idx_t wr_idx_i,
  input  weight_t   wr_weight_i,
  input  logic      clear_i,
  input  node_idx_t limit_i,
  input  merge_t    merge_i,
  input  scan_t     scan_i,
  output scan_t     scan_o
);

  weight_t weight_q;
  logic    linked_q;
  scan_t   scan_d, scan_q;
  logic    eligible;

  // weight: loaded leaf count or merged sum
  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_idx_i == cell_idx_i)) begin
      weight_q <= wr_weight_i;
    end else if (merge_i.en && (merge_i.parent == cell_idx_i)) begin
      weight_q <= merge_i.weight;
    end
  end

  // linked flag: node already has a parent
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      linked_q <= 1'b0;
    end else if (clear_i) begin
      linked_q <= 1'b0;
    end else if (merge_i.en &&
                 ((merge_i.left == cell_idx_i) || (merge_i.right == cell_idx_i))) begin
      linked_q <= 1'b1;
    end
  end

  // insert own weight into the running two smallest, earlier index wins ties
  always_comb begin
    eligible = !linked_q && (cell_idx_i < limit_i);
    scan_d   = scan_i;
    if (eligible && (!scan_i.v1 || (weight_q < scan_i.w1))) begin
      scan_d.v1   = 1'b1;
      scan_d.idx1 = cell_idx_i;
      scan_d.w1   = weight_q;
      scan_d.v2   = scan_i.v1;
      scan_d.idx2 = scan_i.idx1;
      scan_d.w2   = scan_i.w1;
    end else if (eligible && (!scan_i.v2 || (weight_q < scan_i.w2))) begin
      scan_d.v2   = 1'b1;
      scan_d.idx2 = cell_idx_i;
      scan_d.w2   = weight_q;
    end
  end

  // hand the packet to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
    end else begin
      scan_q <= scan_d;
    end
  end

  assign scan_o = scan_q;

endmodule

@@ rtl/hcb_leaf_cell.sv @@
// ----------------------------------------------------------------------------
// hcb_leaf_cell
// One leaf: symbol, code built bottom-up at each merge, and its current
// subtree root; shifts toward the output during emission.
// ----------------------------------------------------------------------------
module hcb_leaf_cell import hcb_pkg::*; (
  input  logic             clk_i,
  input  leaf_idx_t        cell_idx_i,
  input  logic             wr_en_i,
  input  leaf_idx_t        wr_idx_i,
  input  logic [SYM_W-1:0] wr_symbol_i,
  input  merge_t           merge_i,
  input  logic             shift_i,
  input  leaf_t            next_i,
  output leaf_t            leaf_o
);

  leaf_t     leaf_q, merged;
  node_idx_t root_q;
  logic      hit;

  // prepend one edge above the current code
  always_comb begin
    hit    = merge_i.en && ((root_q == merge_i.left) || (root_q == merge_i.right));
    merged = leaf_q;
    if ((root_q == merge_i.right) && (leaf_q.len < LEN_W'(CODE_W))) begin
      merged.code[leaf_q.len] = 1'b1;
    end
    if (leaf_q.len != '1) begin
      merged.len = leaf_q.len + LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_idx_i == cell_idx_i)) begin
      leaf_q.symbol <= wr_symbol_i;
      leaf_q.code   <= '0;
      leaf_q.len    <= '0;
      root_q        <= node_idx_t'(cell_idx_i);
    end else if (shift_i) begin
      leaf_q <= next_i;
    end else if (hit) begin
      leaf_q <= merged;
      root_q <= merge_i.parent;
    end
  end

  assign leaf_o = leaf_q;

endmodule

@@ rtl/huffman_code_builder.sv @@
// Operation: loading takes one pair per cycle; after the last pair, the build
// makes k - 1 merges for k leaves, each waiting for the two-smallest packet
// to cross all 63 node cells, then gives one code per cycle while out_ready_i
// is high. One set at a time: input is held off from the last pair until the
// final code transfer. Reset clears the leaf count, the dropped flag, the
// linked flags and the controller; node and leaf storage is written before use.
// ----------------------------------------------------------------------------
// huffman_code_builder
// Huffman code construction over a row of node cells and a row of leaf cells.
// ----------------------------------------------------------------------------
module huffman_code_builder import hcb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [SYM_W-1:0]      symbol_i,
  input  logic [COUNT_BITS-1:0] count_i,
  input  logic                  last_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [SYM_W-1:0]      out_symbol_o,
  output logic [CODE_W-1:0]     code_bits_o,
  output logic [LEN_W-1:0]      code_length_o,
  output logic                  overflow_o,
  output logic                  end_of_table_o
);

  state_e    state_q, state_d;
  leaf_cnt_t count_q, count_d;
  leaf_cnt_t emit_cnt_q, emit_cnt_d;
  node_idx_t merge_idx_q, merge_idx_d;
  logic      dropped_q, dropped_d;
  logic      wr_en, clear, inject, shift, last_emit;
  merge_t    merge;
  scan_t     scan_chain [NODE_DEPTH+1];
  leaf_t     leaf_chain [MAX_SYMBOLS+1];
  logic [LEAF_CNT_W:0] dbl_k;

  // index of the root node, 2k - 2
  assign dbl_k     = {count_q, 1'b0} - (LEAF_CNT_W+1)'(2);
  assign last_emit = (emit_cnt_q == (count_q - LEAF_CNT_W'(1)));

  // search packet enters at the first node cell
  always_comb begin
    scan_chain[0]    = '0;
    scan_chain[0].go = inject;
  end

  assign merge.en     = (state_q == S_WAIT) && scan_chain[NODE_DEPTH].go;
  assign merge.left   = scan_chain[NODE_DEPTH].idx1;
  assign merge.right  = scan_chain[NODE_DEPTH].idx2;
  assign merge.parent = merge_idx_q;
  assign merge.weight = scan_chain[NODE_DEPTH].w1 + scan_chain[NODE_DEPTH].w2;

  // node cells
  for (genvar j = 0; j < NODE_DEPTH; j++) begin : g_node
    hcb_node_cell u_node (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (node_idx_t'(j)),
      .wr_en_i    (wr_en),
      .wr_idx_i   (node_idx_t'(count_q)),
      .wr_weight_i(WEIGHT_W'(count_i)),
      .clear_i    (clear),
      .limit_i    (merge_idx_q),
      .merge_i    (merge),
      .scan_i     (scan_chain[j]),
      .scan_o     (scan_chain[j+1])
    );
  end

  // leaf cells, cell 0 faces the output
  assign leaf_chain[MAX_SYMBOLS] = '0;
  for (genvar j = 0; j < MAX_SYMBOLS; j++) begin : g_leaf
    hcb_leaf_cell u_leaf (
      .clk_i      (clk_i),
      .cell_idx_i (leaf_idx_t'(j)),
      .wr_en_i    (wr_en),
      .wr_idx_i   (count_q[LEAF_IDX_W-1:0]),
      .wr_symbol_i(symbol_i),
      .merge_i    (merge),
      .shift_i    (shift),
      .next_i     (leaf_chain[j+1]),
      .leaf_o     (leaf_chain[j])
    );
  end

  // controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      count_q     <= '0;
      emit_cnt_q  <= '0;
      merge_idx_q <= '0;
      dropped_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      emit_cnt_q  <= emit_cnt_d;
      merge_idx_q <= merge_idx_d;
      dropped_q   <= dropped_d;
    end
  end

  // next state and controls
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    emit_cnt_d  = emit_cnt_q;
    merge_idx_d = merge_idx_q;
    dropped_d   = dropped_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    wr_en       = 1'b0;
    clear       = 1'b0;
    inject      = 1'b0;
    shift       = 1'b0;
    unique case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (count_q != LEAF_CNT_W'(MAX_SYMBOLS)) begin
            wr_en   = 1'b1;
            count_d = count_q + LEAF_CNT_W'(1);
          end else begin
            dropped_d = 1'b1;
          end
          if (last_i) begin
            state_d = S_INIT;
          end
        end
      end
      S_INIT: begin
        clear       = 1'b1;
        merge_idx_d = node_idx_t'(count_q);
        emit_cnt_d  = '0;
        state_d     = (count_q == LEAF_CNT_W'(1)) ? S_EMIT : S_SCAN;
      end
      S_SCAN: begin
        inject  = 1'b1;
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (merge.en) begin
          merge_idx_d = merge_idx_q + node_idx_t'(1);
          state_d     = (merge_idx_q == node_idx_t'(dbl_k)) ? S_EMIT : S_SCAN;
        end
      end
      S_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          shift      = 1'b1;
          emit_cnt_d = emit_cnt_q + LEAF_CNT_W'(1);
          if (last_emit) begin
            state_d   = S_LOAD;
            count_d   = '0;
            dropped_d = 1'b0;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  // result fields
  assign out_symbol_o   = leaf_chain[0].symbol;
  assign code_bits_o    = leaf_chain[0].code;
  assign code_length_o  = leaf_chain[0].len;
  assign overflow_o     = dropped_q;
  assign end_of_table_o = last_emit;

  // merge always joins two distinct parentless nodes
  a_merge_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    merge.en |-> (scan_chain[NODE_DEPTH].v1 && scan_chain[NODE_DEPTH].v2 &&
                  (merge.left != merge.right)))
    else $error("merge without two distinct nodes");

  // left child is never heavier than right child
  a_merge_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    merge.en |-> (scan_chain[NODE_DEPTH].w1 <= scan_chain[NODE_DEPTH].w2))
    else $error("merge children out of order");

  // leaf count stays within capacity
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= LEAF_CNT_W'(MAX_SYMBOLS))
    else $error("leaf count beyond capacity");

  // after the final code transfer the block takes a new set
  a_table_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && end_of_table_o) |=> (in_ready_o && (count_q == '0)))
    else $error("block not empty after table");

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Loads symbol sets into the Huffman code builder under random idling and
// compares every emitted code against a tree built alongside in the bench.
// ----------------------------------------------------------------------------
module tb_top;
  import hcb_pkg::*;

  typedef struct {
    logic [SYM_W-1:0]      sym;
    logic [COUNT_BITS-1:0] cnt;
    logic                  last;
    bit                    drain_first;
  } pair_t;

  typedef struct {
    logic [SYM_W-1:0]  sym;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic              ovf;
    logic              eot;
  } code_t;

  localparam int LIMIT = 1500000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [SYM_W-1:0]      symbol_i = '0;
  logic [COUNT_BITS-1:0] count_i = '0;
  logic                  last_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [SYM_W-1:0]      out_symbol_o;
  logic [CODE_W-1:0]     code_bits_o;
  logic [LEN_W-1:0]      code_length_o;
  logic                  overflow_o;
  logic                  end_of_table_o;

  pair_t pending_pairs[$];
  code_t expected_codes[$];
  int    n_errors = 0;
  int    n_pairs_taken = 0;
  int    cycle_cnt = 0;

  // set under construction
  logic [SYM_W-1:0] set_sym[MAX_SYMBOLS];
  longint           set_wt[MAX_SYMBOLS];
  int               set_size = 0;
  bit               set_dropped = 0;

  huffman_code_builder i_dut (.*);

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("%0t timeout", $time);
      $display("tb_top: FAIL");
      $finish;
    end
  end

  function automatic int rand_gap();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // build the tree over the set and queue one code per leaf
  task automatic build_codes();
    longint w[NODE_DEPTH];
    int     par[NODE_DEPTH];
    bit     is_left[NODE_DEPTH];
    bit     linked[NODE_DEPTH];
    int     a, b, cur, len;
    code_t  c;
    for (int i = 0; i < NODE_DEPTH; i++) begin
      w[i] = (i < set_size) ? set_wt[i] : 0;
      linked[i] = 0;
      is_left[i] = 0;
      par[i] = 0;
    end
    for (int n = set_size; n < 2 * set_size - 1; n++) begin
      a = -1;
      b = -1;
      for (int i = 0; i < n; i++)
        if (!linked[i] && (a < 0 || w[i] < w[a])) a = i;
      for (int i = 0; i < n; i++)
        if (!linked[i] && i != a && (b < 0 || w[i] < w[b])) b = i;
      par[a] = n;
      par[b] = n;
      linked[a] = 1;
      linked[b] = 1;
      is_left[a] = 1;
      is_left[b] = 0;
      w[n] = w[a] + w[b];
    end
    for (int i = 0; i < set_size; i++) begin
      c.code = '0;
      len = 0;
      cur = i;
      while (linked[cur]) begin
        if (!is_left[cur] && len < CODE_W) c.code[len] = 1'b1;
        len++;
        cur = par[cur];
      end
      c.sym = set_sym[i];
      c.len = LEN_W'((len > CODE_W) ? CODE_W : len);
      c.ovf = set_dropped;
      c.eot = (i == set_size - 1);
      expected_codes.push_back(c);
    end
    set_size = 0;
    set_dropped = 0;
  endtask

  task automatic take_pair(pair_t p);
    if (set_size < MAX_SYMBOLS) begin
      set_sym[set_size] = p.sym;
      set_wt[set_size] = longint'(p.cnt);
      set_size++;
    end else begin
      set_dropped = 1;
    end
    if (p.last) build_codes();
  endtask

  // input driver
  int in_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    logic nv;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      nv = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        take_pair(pending_pairs.pop_front());
        n_pairs_taken++;
        nv = 1'b0;
        in_gap = rand_gap();
      end
      if (!nv) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_pairs.size() > 0 &&
                     (!pending_pairs[0].drain_first || expected_codes.size() == 0)) begin
          nv = 1'b1;
          symbol_i <= pending_pairs[0].sym;
          count_i  <= pending_pairs[0].cnt;
          last_i   <= pending_pairs[0].last;
        end
      end
      in_valid_i <= nv;
    end
  end

  // output monitor with random back-pressure and one long hold-off
  int out_gap = 0;
  int hold_left = 0;
  bit hold_done = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    code_t e;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_codes.size() == 0) begin
          $display("%0t unexpected code: sym %h code %h len %0d", $time,
                   out_symbol_o, code_bits_o, code_length_o);
          n_errors++;
        end else begin
          e = expected_codes.pop_front();
          if (out_symbol_o !== e.sym) begin
            $display("%0t out_symbol exp %h act %h", $time, e.sym, out_symbol_o);
            n_errors++;
          end
          if (code_bits_o !== e.code) begin
            $display("%0t code_bits exp %h act %h", $time, e.code, code_bits_o);
            n_errors++;
          end
          if (code_length_o !== e.len) begin
            $display("%0t code_length exp %0d act %0d", $time, e.len, code_length_o);
            n_errors++;
          end
          if (overflow_o !== e.ovf) begin
            $display("%0t overflow exp %b act %b", $time, e.ovf, overflow_o);
            n_errors++;
          end
          if (end_of_table_o !== e.eot) begin
            $display("%0t end_of_table exp %b act %b", $time, e.eot, end_of_table_o);
            n_errors++;
          end
        end
      end
      if (!hold_done && n_pairs_taken >= 120) begin
        hold_done = 1;
        hold_left = 5000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        out_gap = rand_gap();
      end
    end
  end

  function automatic logic [COUNT_BITS-1:0] rand_count();
    int r;
    r = $urandom_range(7);
    if (r < 2) return COUNT_BITS'($urandom_range(3));
    if (r == 2) return $urandom_range(1) ? '1 : '0;
    return COUNT_BITS'($urandom());
  endfunction

  task automatic add_pair(int sym, logic [COUNT_BITS-1:0] cnt, bit last, bit drain);
    pair_t p;
    p.sym = SYM_W'(sym);
    p.cnt = cnt;
    p.last = last;
    p.drain_first = drain;
    pending_pairs.push_back(p);
  endtask

  // stimulus and end of run
  initial begin
    int n_items, sz, r;
    bit drain;
    // lone symbol at the top extremes
    add_pair(8'hFF, '1, 1, 0);
    // two leaves at opposite extremes
    add_pair(8'h00, 24'd1, 0, 0);
    add_pair(8'hFF, '1, 1, 0);
    // zero counts and duplicate symbols
    add_pair(8'h05, '0, 0, 1);
    add_pair(8'h05, '0, 0, 0);
    add_pair(8'hAA, 24'd3, 1, 0);
    // equal weights exercise tie breaking
    for (int i = 0; i < 5; i++) add_pair(8'h55 + i, 24'd7, i == 4, 0);
    // full set with dropped pairs, last pair itself dropped
    for (int i = 0; i < 34; i++) add_pair(i * 7, rand_count(), i == 33, 0);
    n_items = 45;
    while (n_items < 460) begin
      r = $urandom_range(99);
      if (r < 80) sz = $urandom_range(8, 1);
      else if (r < 92) sz = $urandom_range(31, 9);
      else sz = $urandom_range(36, 32);
      drain = ($urandom_range(9) == 0);
      for (int i = 0; i < sz; i++)
        add_pair($urandom_range(255), rand_count(), i == sz - 1, drain && i == 0);
      n_items += sz;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_pairs.size() == 0 && expected_codes.size() == 0);
    repeat (200) @(posedge clk_i);
    if (n_errors == 0 && expected_codes.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/hcb_pkg.sv
rtl/hcb_node_cell.sv
rtl/hcb_leaf_cell.sv
rtl/huffman_code_builder.sv
tb/sv/tb_top.sv
